>>> hw/rtl/ffh_pkg.sv
package ffh_pkg;

  // heap geometry
  localparam int unsigned HEAP_BYTES   = 1024;
  localparam int unsigned HEADER_BYTES = 36;
  localparam int unsigned MAX_SEGMENTS = 32;

  // field and index widths
  localparam int unsigned AW = 10;
  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = IW + 1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OOM       = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // one segment table entry
  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] len;
    logic          free;
  } seg_t;

  // command broadcast to every cell
  typedef struct packed {
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    seg_t          wr_seg;
    logic          up_en;
    logic          dn_en;
    logic [CW-1:0] sh_idx;
  } cmd_t;

endpackage

>>> hw/rtl/ffh_cell.sv
module ffh_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ffh_pkg::IW-1:0]    idx_i,
  input  ffh_pkg::cmd_t             cmd_i,
  input  ffh_pkg::seg_t             lower_i,
  input  ffh_pkg::seg_t             upper_i,
  output ffh_pkg::seg_t             seg_o
);

  ffh_pkg::seg_t seg_q, seg_d;
  logic [ffh_pkg::CW-1:0] idx_ext;

  assign idx_ext = {1'b0, idx_i};

  // write wins, otherwise take a neighbor on a shift
  always_comb begin
    seg_d = seg_q;
    if (cmd_i.wr_en && (cmd_i.wr_idx == idx_i)) begin
      seg_d = cmd_i.wr_seg;
    end else if (cmd_i.up_en && (idx_ext > cmd_i.sh_idx)) begin
      seg_d = lower_i;
    end else if (cmd_i.dn_en && (idx_ext >= cmd_i.sh_idx)) begin
      seg_d = upper_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q.start <= '0;
      seg_q.len   <= ffh_pkg::AW'(ffh_pkg::HEAP_BYTES - ffh_pkg::HEADER_BYTES);
      seg_q.free  <= 1'b1;
    end else begin
      seg_q <= seg_d;
    end
  end

  assign seg_o = seg_q;

endmodule

>>> hw/rtl/first_fit_heap_allocator.sv
// First-fit heap allocator with coalescing over an address-ordered segment table.
// Input channel s_axis: tuser carries the operation (0 allocate, 1 free),
// tdata carries request_bytes and release_offset. Output channel m_axis: tdata
// carries payload_offset and status (0 done, 1 out of memory, 2 not found).
// Every input transaction yields exactly one output transaction.
// The table is a row of cells, one entry each; inserts and removals move all
// entries past a point by one place toward their neighbor, all at once.
// An item is accepted in S_IDLE; S_SCAN then walks the table entry by entry
// (up to 32 entries, and one more step when no entry matches). A hit goes on to
// S_AWR for an allocate, or to S_FNEXT and S_FPREV for a free, and S_DONE loads
// the result register. A new item is accepted only once S_DONE has handed off.
// At reset the table holds a single free segment at offset 0 with
// 988 payload bytes; no clearing pass is needed.
// The result sits in an output register; when the receiver stalls, the block
// finishes the next item and then waits until the held result is taken.
module first_fit_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // request_bytes[9:0], release_offset[19:10], zeros
  input  logic        s_axis_tuser_i,   // operation[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // payload_offset[9:0], status[11:10], zeros
);

  localparam int unsigned AW = ffh_pkg::AW;
  localparam int unsigned IW = ffh_pkg::IW;
  localparam int unsigned CW = ffh_pkg::CW;
  localparam int unsigned NS = ffh_pkg::MAX_SEGMENTS;
  localparam logic [AW:0] HDR = (AW+1)'(ffh_pkg::HEADER_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(ffh_pkg::MAX_SEGMENTS);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_AWR, S_FNEXT, S_FPREV, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic op_q, op_d, split_q, split_d, prev_free_q, prev_free_d;
  logic [AW-1:0] req_q, req_d, rel_q, rel_d;
  logic [AW-1:0] cur_len_q, cur_len_d, hit_start_q, hit_start_d;
  logic [AW-1:0] prev_len_q, prev_len_d, prev_start_q, prev_start_d;
  logic [CW-1:0] ptr_q, ptr_d, hit_q, hit_d, cnt_q, cnt_d;
  logic [AW-1:0] res_off_q, res_off_d;
  ffh_pkg::status_e res_st_q, res_st_d;
  logic out_valid_q, out_valid_d;
  logic [AW-1:0] out_off_q, out_off_d;
  ffh_pkg::status_e out_st_q, out_st_d;

  ffh_pkg::cmd_t cmd;
  ffh_pkg::seg_t segs [NS];
  ffh_pkg::seg_t rd;
  logic [AW:0] sum_a, sum_b;
  logic [CW-1:0] ptr_inc;

  // row of cells
  for (genvar k = 0; k < NS; k++) begin : g_cell
    ffh_pkg::seg_t lo, up;
    if (k == 0) begin : g_lo0
      assign lo = segs[k];
    end else begin : g_lo
      assign lo = segs[k-1];
    end
    if (k == NS - 1) begin : g_upn
      assign up = segs[k];
    end else begin : g_up
      assign up = segs[k+1];
    end
    ffh_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IW'(k)),
      .cmd_i   (cmd),
      .lower_i (lo),
      .upper_i (up),
      .seg_o   (segs[k])
    );
  end

  assign rd      = segs[ptr_q[IW-1:0]];
  assign ptr_inc = ptr_q + CW'(1);

  // sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    req_d        = req_q;
    rel_d        = rel_q;
    split_d      = split_q;
    prev_free_d  = prev_free_q;
    prev_len_d   = prev_len_q;
    prev_start_d = prev_start_q;
    cur_len_d    = cur_len_q;
    hit_start_d  = hit_start_q;
    ptr_d        = ptr_q;
    hit_d        = hit_q;
    cnt_d        = cnt_q;
    res_off_d    = res_off_q;
    res_st_d     = res_st_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_off_d    = out_off_q;
    out_st_d     = out_st_q;
    cmd          = '0;
    sum_a        = '0;
    sum_b        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d        = s_axis_tuser_i;
          req_d       = s_axis_tdata_i[AW-1:0];
          rel_d       = s_axis_tdata_i[2*AW-1:AW];
          ptr_d       = '0;
          prev_free_d = 1'b0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        sum_a = {1'b0, rd.start} + HDR;
        if (ptr_q == cnt_q) begin
          res_off_d = '0;
          res_st_d  = op_q ? ffh_pkg::ST_NOT_FOUND : ffh_pkg::ST_OOM;
          state_d   = S_DONE;
        end else if (!op_q) begin
          if (rd.free && (rd.len >= req_q)) begin
            hit_d       = ptr_q;
            hit_start_d = rd.start;
            cur_len_d   = rd.len;
            res_off_d   = sum_a[AW-1:0];
            sum_b       = {1'b0, req_q} + HDR;
            split_d     = ({1'b0, rd.len} > sum_b) && (cnt_q < MAXC);
            if (split_d) begin
              cmd.wr_en        = 1'b1;
              cmd.wr_idx       = ptr_inc[IW-1:0];
              cmd.wr_seg.start = AW'(sum_a + {1'b0, req_q});
              cmd.wr_seg.len   = AW'({1'b0, rd.len} - sum_b);
              cmd.wr_seg.free  = 1'b1;
              cmd.up_en        = 1'b1;
              cmd.sh_idx       = ptr_inc;
              cnt_d            = cnt_q + CW'(1);
            end
            state_d = S_AWR;
          end else begin
            ptr_d = ptr_inc;
          end
        end else begin
          if (sum_a == {1'b0, rel_q}) begin
            hit_d       = ptr_q;
            hit_start_d = rd.start;
            cur_len_d   = rd.len;
            ptr_d       = ptr_inc;
            state_d     = S_FNEXT;
          end else begin
            prev_free_d  = rd.free;
            prev_len_d   = rd.len;
            prev_start_d = rd.start;
            ptr_d        = ptr_inc;
          end
        end
      end
      S_AWR: begin
        cmd.wr_en        = 1'b1;
        cmd.wr_idx       = hit_q[IW-1:0];
        cmd.wr_seg.start = hit_start_q;
        cmd.wr_seg.len   = split_q ? req_q : cur_len_q;
        cmd.wr_seg.free  = 1'b0;
        res_st_d         = ffh_pkg::ST_DONE;
        state_d          = S_DONE;
      end
      S_FNEXT: begin
        cmd.wr_en        = 1'b1;
        cmd.wr_idx       = hit_q[IW-1:0];
        cmd.wr_seg.start = hit_start_q;
        cmd.wr_seg.len   = cur_len_q;
        cmd.wr_seg.free  = 1'b1;
        if ((ptr_q < cnt_q) && rd.free) begin
          sum_b          = {1'b0, cur_len_q} + HDR + {1'b0, rd.len};
          cur_len_d      = sum_b[AW-1:0];
          cmd.wr_seg.len = sum_b[AW-1:0];
          cmd.dn_en      = 1'b1;
          cmd.sh_idx     = ptr_q;
          cnt_d          = cnt_q - CW'(1);
        end
        state_d = S_FPREV;
      end
      S_FPREV: begin
        if ((hit_q != '0) && prev_free_q) begin
          sum_b            = {1'b0, prev_len_q} + HDR + {1'b0, cur_len_q};
          cmd.wr_en        = 1'b1;
          cmd.wr_idx       = IW'(hit_q - CW'(1));
          cmd.wr_seg.start = prev_start_q;
          cmd.wr_seg.len   = sum_b[AW-1:0];
          cmd.wr_seg.free  = 1'b1;
          cmd.dn_en        = 1'b1;
          cmd.sh_idx       = hit_q;
          cnt_d            = cnt_q - CW'(1);
        end
        res_off_d = '0;
        res_st_d  = ffh_pkg::ST_DONE;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_off_d   = res_off_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= CW'(1);
      out_valid_q <= 1'b0;
      out_off_q   <= '0;
      out_st_q    <= ffh_pkg::ST_DONE;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_off_q   <= out_off_d;
      out_st_q    <= out_st_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    req_q        <= req_d;
    rel_q        <= rel_d;
    split_q      <= split_d;
    prev_free_q  <= prev_free_d;
    prev_len_q   <= prev_len_d;
    prev_start_q <= prev_start_d;
    cur_len_q    <= cur_len_d;
    hit_start_q  <= hit_start_d;
    ptr_q        <= ptr_d;
    hit_q        <= hit_d;
    res_off_q    <= res_off_d;
    res_st_q     <= res_st_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_st_q, out_off_q};

endmodule

>>> hw/rtl/ffh_checker.sv
module ffh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed under stall");

  // status code is defined
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[11:10] != 2'd3)
    else $error("bad status code");

  // failures carry no offset
  a_fail_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[11:10] != 2'd0 |-> m_axis_tdata_o[9:0] == 10'd0)
    else $error("offset on failure");

  // a granted payload lies past a header
  a_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[9:0] != 10'd0
      |-> m_axis_tdata_o[9:0] >= 10'(ffh_pkg::HEADER_BYTES))
    else $error("offset inside a header");

endmodule

bind first_fit_heap_allocator ffh_checker u_ffh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
